### hdl/tcq_pkg.sv
// Shared types and constants for the timed callback queue.
package tcq_pkg;

  localparam int HANDLE_W = 8;
  localparam int TIME_W   = 32;
  localparam int MAX_OUT  = 8;

  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [TIME_W-1:0]   time_t;

  localparam time_t HALF_RANGE = 32'h8000_0000;
  localparam time_t NONE_EVENT = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OP_SCHEDULE = 3'd0,
    OP_CANCEL   = 3'd1,
    OP_QUERY    = 3'd2,
    OP_EXPIRE   = 3'd3,
    OP_DRAIN    = 3'd4
  } op_t;

endpackage

### hdl/timed_callback_queue.sv
// Timed callback queue: slot table, scan sequencer and result register.
//
// A table of SLOT_COUNT callback slots. Each request is taken while in_stall is low and
// the sequencer then walks the slots in order, using one subtractor (diff) for the slot
// and arm comparisons; the target sum is formed when the request is taken. The slot
// handles and targets live in a one-port memory with a registered read, so each slot
// that needs its stored data passes through the extra state S_EVAL. A request with
// handle zero (schedule, cancel, query) or an unknown operation goes straight to the
// result; schedule stops at the first free slot, cancel and query at the first match.
// Drain gives one result per pending slot (at most eight per request) and holds its scan
// while out_stall is high. The result register decouples the two sides: a new request can
// be taken while the previous result is still waiting. No clearing pass after reset.
module timed_callback_queue #(
  parameter int SLOT_COUNT  = 8,
  parameter int HANDLE_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                operation,
  input  logic [7:0]                handle,
  input  logic [31:0]               interval,
  input  logic [31:0]               now_us,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      success,
  output logic [31:0]               next_event_us,
  output logic                      compare_armed,
  output logic [7:0]                due_handle,
  output logic                      has_due,
  output logic                      last
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int HW    = (HANDLE_BITS < tcq_pkg::HANDLE_W) ? HANDLE_BITS : tcq_pkg::HANDLE_W;
  localparam int CNT_W = $clog2(tcq_pkg::MAX_OUT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_EVAL,
    S_ARM,
    S_EXP_END,
    S_FIN
  } state_t;

  state_t                state;
  logic [IDX_W-1:0]      idx;
  logic [2:0]            op;
  logic [HW-1:0]         hreg;
  tcq_pkg::time_t        delay;
  tcq_pkg::time_t        now;
  tcq_pkg::time_t        target;
  logic                  ok;
  logic                  found;
  tcq_pkg::time_t        best;
  tcq_pkg::time_t        best_until;
  logic [CNT_W-1:0]      cnt;
  logic [HW-1:0]         hold;
  logic                  hold_valid;
  logic [SLOT_COUNT-1:0] slot_active;
  logic [SLOT_COUNT-1:0] slot_pending;
  tcq_pkg::time_t        soonest;
  logic                  armed;

  // slot store, one write and one registered read per cycle
  logic [HW-1:0]         mem_handle [SLOT_COUNT];
  tcq_pkg::time_t        mem_target [SLOT_COUNT];
  logic [HW-1:0]         rd_handle;
  tcq_pkg::time_t        rd_target;
  logic                  mem_we;

  // shared unit
  tcq_pkg::time_t        sub_a;
  tcq_pkg::time_t        diff;

  logic                  idx_last;
  logic                  relevant;
  logic                  out_free;
  logic                  res_load;
  logic                  null_handle;
  state_t                scan_done;
  state_t                adv_state;
  logic [IDX_W-1:0]      adv_idx;

  assign in_stall    = (state != S_IDLE);
  assign out_free    = !out_valid || !out_stall;
  // result register is loaded this cycle
  assign res_load    = out_free && ((state == S_FIN) ||
                       ((state == S_EVAL) && (op == tcq_pkg::OP_DRAIN) && hold_valid));
  assign idx_last    = (idx == IDX_W'(SLOT_COUNT - 1));
  assign relevant    = (op == tcq_pkg::OP_DRAIN) ? slot_pending[idx] : slot_active[idx];
  assign null_handle = (handle[HW-1:0] == '0);
  assign scan_done   = (op == tcq_pkg::OP_EXPIRE) ? S_EXP_END : S_FIN;
  assign adv_state   = idx_last ? scan_done : S_ADDR;
  assign adv_idx     = idx_last ? idx : idx + IDX_W'(1);
  assign mem_we      = (state == S_ADDR) && (op == tcq_pkg::OP_SCHEDULE) && !slot_active[idx];

  assign sub_a = (state == S_ARM) ? soonest : rd_target;
  assign diff  = sub_a - now;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_handle[idx] <= hreg;
      mem_target[idx] <= target;
    end
    rd_handle <= mem_handle[idx];
    rd_target <= mem_target[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      slot_active  <= '0;
      slot_pending <= '0;
      soonest      <= tcq_pkg::NONE_EVENT;
      armed        <= 1'b0;
      hold_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !res_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op         <= operation;
            hreg       <= handle[HW-1:0];
            delay      <= interval;
            now        <= now_us;
            target     <= now_us + interval;
            ok         <= 1'b0;
            found      <= 1'b0;
            cnt        <= '0;
            hold_valid <= 1'b0;
            idx        <= '0;
            if (operation > tcq_pkg::OP_DRAIN) begin
              state <= S_FIN;
            end else if (operation <= tcq_pkg::OP_QUERY && null_handle) begin
              state <= S_FIN;
            end else begin
              state <= S_ADDR;
            end
          end
        end
        S_ADDR: begin
          if (op == tcq_pkg::OP_SCHEDULE) begin
            if (!slot_active[idx]) begin
              slot_active[idx]  <= 1'b1;
              slot_pending[idx] <= 1'b0;
              ok                <= 1'b1;
              state             <= S_ARM;
            end else begin
              idx   <= adv_idx;
              state <= adv_state;
            end
          end else if (relevant) begin
            state <= S_EVAL;
          end else begin
            idx   <= adv_idx;
            state <= adv_state;
          end
        end
        S_EVAL: begin
          case (op)
            tcq_pkg::OP_CANCEL, tcq_pkg::OP_QUERY: begin
              if (rd_handle == hreg) begin
                ok <= 1'b1;
                if (op == tcq_pkg::OP_CANCEL) begin
                  slot_active[idx] <= 1'b0;
                end
                state <= S_FIN;
              end else begin
                idx   <= adv_idx;
                state <= adv_state;
              end
            end
            tcq_pkg::OP_EXPIRE: begin
              // a target less than half the range behind now counts as overdue
              if (diff > tcq_pkg::HALF_RANGE) begin
                slot_pending[idx] <= 1'b1;
                slot_active[idx]  <= 1'b0;
              end else if (!found || diff < best_until) begin
                best       <= rd_target;
                best_until <= diff;
                found      <= 1'b1;
              end
              idx   <= adv_idx;
              state <= adv_state;
            end
            tcq_pkg::OP_DRAIN: begin
              // one handle held back so the final one can carry last
              if (!hold_valid || out_free) begin
                if (hold_valid) begin
                  out_valid     <= 1'b1;
                  success       <= 1'b1;
                  next_event_us <= soonest;
                  compare_armed <= armed;
                  due_handle    <= tcq_pkg::handle_t'(hold);
                  has_due       <= 1'b1;
                  last          <= 1'b0;
                end
                hold              <= rd_handle;
                hold_valid        <= 1'b1;
                slot_pending[idx] <= 1'b0;
                if (cnt == CNT_W'(tcq_pkg::MAX_OUT - 1)) begin
                  state <= S_FIN;
                end else begin
                  cnt   <= cnt + CNT_W'(1);
                  idx   <= adv_idx;
                  state <= adv_state;
                end
              end
            end
            default: begin
              state <= S_FIN;
            end
          endcase
        end
        S_ARM: begin
          if (delay < diff) begin
            soonest <= target;
            armed   <= 1'b1;
          end
          state <= S_FIN;
        end
        S_EXP_END: begin
          if (found) begin
            soonest <= best;
          end else begin
            soonest <= tcq_pkg::NONE_EVENT;
            armed   <= 1'b0;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            success       <= hold_valid | ok;
            next_event_us <= soonest;
            compare_armed <= armed;
            due_handle    <= hold_valid ? tcq_pkg::handle_t'(hold) : '0;
            has_due       <= hold_valid;
            last          <= 1'b1;
            hold_valid    <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted without the sequencer going busy");

  a_active_pending_excl: assert property (@(posedge clk) disable iff (rst)
    (slot_active & slot_pending) == '0)
    else $error("slot both active and pending");

  a_only_drain_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> has_due && success)
    else $error("non-final result that is not a due callback");

  a_due_is_success: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_due |-> success)
    else $error("due callback reported without success");

endmodule
